### design/lei_pkg.sv
// shared types, widths and constants for the log/exp table interpolator
// also holds the elaboration-time functions that build the two sample tables
// no dependencies
package lei_pkg;

    // table size and derived index width
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    // field widths
    localparam int ARG_W = 32;
    localparam int RES_W = 20;
    localparam int FRAC_W = 16;
    localparam int ENTRY_W = 32;

    // function select codes
    localparam logic KIND_LOG = 1'b0;
    localparam logic KIND_EXP = 1'b1;

    // register stages from the input to the blended result
    localparam int INDEX_STAGES = 6;
    localparam int INTERP_STAGES = 2;
    localparam int PIPE_STAGES = INDEX_STAGES + INTERP_STAGES;

    // result buffer covers every item in flight plus the buffer slot itself
    localparam int FIFO_DEPTH = 2 ** $clog2(PIPE_STAGES + 3);

    typedef logic signed [ENTRY_W-1:0] t_entry;

    // table position handed from the index pipe to the interpolator
    typedef struct packed {
        logic             valid;
        logic             kind;
        logic [IDX_W-1:0] i0;
        logic [IDX_W-1:0] i1;
        logic [FRAC_W-1:0] f;
    } t_idx;

    // blended result on its way into the output buffer
    typedef struct packed {
        logic                    valid;
        logic signed [RES_W-1:0] value;
    } t_res;

    // q2.30 helpers for building the tables
    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint LN2_Q30 = 64'sd744261118;

    // restoring long division, evaluated only while elaborating
    function automatic longint unsigned lei_udiv(input longint unsigned num,
                                                 input longint unsigned den);
        logic [64:0]     rem;
        longint unsigned quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // ln(num/den) in q2.30 via the atanh series
    function automatic longint lei_ln_q30(input longint unsigned num,
                                          input longint unsigned den);
        longint unsigned x;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned p;
        longint unsigned sum;
        longint          k;
        x = lei_udiv(num << 30, den);
        k = 0;
        sum = 0;
        if (x == 0) begin
            x = 1;
        end
        for (int s = 0; s < 64; s++) begin
            if (x >= (Q30_ONE << 1)) begin
                x = x >> 1;
                k = k + 1;
            end
        end
        for (int s = 0; s < 64; s++) begin
            if (x < Q30_ONE) begin
                x = x << 1;
                k = k - 1;
            end
        end
        z = lei_udiv((x - Q30_ONE) << 30, x + Q30_ONE);
        z2 = (z * z) >> 30;
        p = z;
        for (int j = 0; j < 40; j++) begin
            if (p != 0) begin
                sum = sum + lei_udiv(p, 64'(2 * j + 1));
                p = (p * z2) >> 30;
            end
        end
        return k * LN2_Q30 + longint'(sum << 1);
    endfunction

    // exp(+/- mag/den) in q2.30 via taylor series, reciprocal when negative
    function automatic longint lei_exp_q30(input longint unsigned mag,
                                           input longint unsigned den,
                                           input logic neg);
        longint unsigned x;
        longint unsigned sum;
        longint unsigned term;
        x = lei_udiv(mag << 30, den);
        sum = Q30_ONE;
        term = Q30_ONE;
        for (int n = 1; n <= 40; n++) begin
            if (term != 0) begin
                term = lei_udiv((term * x) >> 30, 64'(n));
                sum = sum + term;
            end
        end
        if (neg) begin
            return longint'(lei_udiv(64'd1 << 60, sum));
        end
        return longint'(sum);
    endfunction

    // q2.30 to q16.16, halves away from zero
    function automatic t_entry lei_q30_to_q16(input longint v);
        longint r;
        if (v >= 0) begin
            r = (v + 8192) >>> 14;
        end else begin
            r = -((-v + 8192) >>> 14);
        end
        return ENTRY_W'(r);
    endfunction

    // ln(0.1 + 9.9*idx/(entries-1))
    function automatic t_entry lei_log_entry(input int idx);
        longint unsigned m;
        longint unsigned i;
        m = 64'(TABLE_ENTRIES - 1);
        i = 64'(idx);
        return lei_q30_to_q16(lei_ln_q30(m + 99 * i, 10 * m));
    endfunction

    // exp(-2 + 4*idx/(entries-1))
    function automatic t_entry lei_exp_entry(input int idx);
        longint          e;
        longint unsigned m;
        longint unsigned mag;
        m = 64'(TABLE_ENTRIES - 1);
        e = 4 * longint'(idx) - 2 * longint'(m);
        mag = 64'((e < 0) ? -e : e);
        return lei_q30_to_q16(lei_exp_q30(mag, m, e < 0));
    endfunction

endpackage

### design/lei_index.sv
// index pipe: clamps the argument, maps it onto the table and splits the
// position into entry index and q0.16 fraction over six register stages
// depends on lei_pkg
module lei_index (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             i_kind,
    input  logic signed [lei_pkg::ARG_W-1:0] i_arg_value,
    output lei_pkg::t_idx                    o_idx
);
    import lei_pkg::*;

    // span of the clamped offset for each function
    localparam int D_W = 23;
    localparam int LOG_SPAN_I = 6488064;
    localparam int EXP_SPAN_I = 262144;
    localparam int LOG_OFFSET = 65536;
    localparam int EXP_OFFSET = 131072;
    localparam int EXP_SHIFT = 18;
    localparam logic [D_W-1:0] LOG_SPAN = D_W'(LOG_SPAN_I);
    localparam logic [D_W-1:0] EXP_SPAN = D_W'(EXP_SPAN_I);
    localparam int EXT_W = ARG_W + 5;
    localparam int EXPD_W = ARG_W + 2;

    // position and the two divides by 99 (log span is 99 * 2^16)
    localparam int P_W = D_W + IDX_W;
    localparam int X_W = P_W - FRAC_W;
    localparam logic [6:0] DIV_99 = 7'd99;
    localparam int K1 = X_W + 1;
    localparam int M1_W = K1 - 6;
    localparam logic [M1_W-1:0] M1 = M1_W'((64'd1 << K1) / 64'd99);
    localparam int PR1_W = X_W + M1_W;
    localparam int Y_W = 7 + FRAC_W;
    localparam int K2 = Y_W + 1;
    localparam int M2_W = K2 - 6;
    localparam logic [M2_W-1:0] M2 = M2_W'((64'd1 << K2) / 64'd99);
    localparam int PR2_W = Y_W + M2_W;

    logic                  r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    logic                  r1_kind, r2_kind, r3_kind, r4_kind, r5_kind;
    logic [D_W-1:0]        r1_d;
    logic [P_W-1:0]        r2_p;
    logic [IDX_W-1:0]      r3_q, r4_i0, r5_i0;
    logic [FRAC_W-1:0]     r3_lo, r5_f;
    logic [X_W-1:0]        r3_x;
    logic [Y_W-1:0]        r4_y, r5_y;
    logic                  r6_valid, r6_kind;
    logic [IDX_W-1:0]      r6_i0, r6_i1;
    logic [FRAC_W-1:0]     r6_f;

    logic signed [EXT_W-1:0]  w_ext;
    logic signed [EXT_W-1:0]  w_log_d;
    logic signed [EXPD_W-1:0] w_exp_d;
    logic [D_W-1:0]           w_log_c, w_exp_c, n_d;
    logic [X_W-1:0]           w_x;
    logic [PR1_W-1:0]         w_prod1;
    logic [IDX_W-1:0]         w_qest;
    logic [X_W-1:0]           w_q99, w_r;
    logic [IDX_W-1:0]         w_q;
    logic [6:0]               w_rem;
    logic [PR2_W-1:0]         w_prod2;
    logic [FRAC_W-1:0]        w_fest;
    logic [Y_W-1:0]           w_f99, w_r2;
    logic [FRAC_W-1:0]        w_f;
    logic [IDX_W-1:0]         w_i1;

    // stage 1: offset and clamp
    always_comb begin
        w_ext = EXT_W'(i_arg_value);
        w_log_d = (w_ext <<< 3) + (w_ext <<< 1) - EXT_W'(LOG_OFFSET);
        w_exp_d = EXPD_W'(i_arg_value) + EXPD_W'(EXP_OFFSET);
        if (w_log_d < 0) begin
            w_log_c = '0;
        end else if (w_log_d > EXT_W'(LOG_SPAN_I)) begin
            w_log_c = LOG_SPAN;
        end else begin
            w_log_c = w_log_d[D_W-1:0];
        end
        if (w_exp_d < 0) begin
            w_exp_c = '0;
        end else if (w_exp_d > EXPD_W'(EXP_SPAN_I)) begin
            w_exp_c = EXP_SPAN;
        end else begin
            w_exp_c = w_exp_d[D_W-1:0];
        end
        n_d = (i_kind == KIND_EXP) ? w_exp_c : w_log_c;
    end

    // stage 3: reciprocal estimate of position / 99 for log, plain split for exp
    always_comb begin
        w_x = r2_p[P_W-1:FRAC_W];
        w_prod1 = PR1_W'(w_x) * PR1_W'(M1);
        w_qest = w_prod1[K1 +: IDX_W];
    end

    // stage 4: correct the quotient, form the fraction dividend
    always_comb begin
        w_q99 = X_W'(r3_q) * X_W'(DIV_99);
        w_r = r3_x - w_q99;
        if (w_r >= X_W'(DIV_99)) begin
            w_q = r3_q + IDX_W'(1);
            w_rem = 7'(w_r - X_W'(DIV_99));
        end else begin
            w_q = r3_q;
            w_rem = w_r[6:0];
        end
    end

    // stage 5: reciprocal estimate of the fraction
    always_comb begin
        w_prod2 = PR2_W'(r4_y) * PR2_W'(M2);
        w_fest = w_prod2[K2 +: FRAC_W];
    end

    // stage 6: correct the fraction, pick the upper neighbor
    always_comb begin
        w_f99 = Y_W'(r5_f) * Y_W'(DIV_99);
        w_r2 = r5_y - w_f99;
        if (r5_kind == KIND_LOG && w_r2 >= Y_W'(DIV_99)) begin
            w_f = r5_f + FRAC_W'(1);
        end else begin
            w_f = r5_f;
        end
        w_i1 = (r5_i0 == IDX_LAST) ? r5_i0 : r5_i0 + IDX_W'(1);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r1_kind <= i_kind;
        r1_d <= n_d;

        r2_kind <= r1_kind;
        r2_p <= P_W'(r1_d) * P_W'(IDX_LAST);

        r3_kind <= r2_kind;
        r3_x <= w_x;
        if (r2_kind == KIND_EXP) begin
            r3_q <= r2_p[EXP_SHIFT +: IDX_W];
            r3_lo <= r2_p[EXP_SHIFT-1 -: FRAC_W];
        end else begin
            r3_q <= w_qest;
            r3_lo <= r2_p[FRAC_W-1:0];
        end

        r4_kind <= r3_kind;
        if (r3_kind == KIND_EXP) begin
            r4_i0 <= r3_q;
            r4_y <= {7'd0, r3_lo};
        end else begin
            r4_i0 <= w_q;
            r4_y <= {w_rem, r3_lo};
        end

        r5_kind <= r4_kind;
        r5_i0 <= r4_i0;
        r5_y <= r4_y;
        r5_f <= (r4_kind == KIND_EXP) ? r4_y[FRAC_W-1:0] : w_fest;

        r6_kind <= r5_kind;
        r6_i0 <= r5_i0;
        r6_i1 <= w_i1;
        r6_f <= w_f;
    end

    // table position out
    always_comb begin
        o_idx.valid = r6_valid;
        o_idx.kind = r6_kind;
        o_idx.i0 = r6_i0;
        o_idx.i1 = r6_i1;
        o_idx.f = r6_f;
    end

endmodule

### design/lei_interp.sv
// interpolator: constant log and exp tables, neighbor lookup and linear blend
// two register stages; the final add feeds the output buffer directly
// depends on lei_pkg
module lei_interp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lei_pkg::t_idx i_idx,
    output lei_pkg::t_res o_res
);
    import lei_pkg::*;

    localparam int DIFF_W = ENTRY_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_W + 1;
    localparam int HALF = 32768;

    t_entry w_log_rom [TABLE_ENTRIES];
    t_entry w_exp_rom [TABLE_ENTRIES];

    // sample tables, built while elaborating
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_rom
        localparam t_entry LOG_E = lei_log_entry(g);
        localparam t_entry EXP_E = lei_exp_entry(g);
        assign w_log_rom[g] = LOG_E;
        assign w_exp_rom[g] = EXP_E;
    end

    logic                     r7_valid, r8_valid;
    t_entry                   r7_t0, r7_t1, r8_t0;
    logic [FRAC_W-1:0]        r7_f;
    logic signed [PROD_W-1:0] r8_prod;

    logic signed [DIFF_W-1:0] w_diff;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_blend;
    logic signed [PROD_W-1:0] w_sum;

    // stage 8 math: slope times fraction
    always_comb begin
        w_diff = DIFF_W'(r7_t1) - DIFF_W'(r7_t0);
        w_prod = PROD_W'(w_diff) * PROD_W'($signed({1'b0, r7_f}));
    end

    // final blend with rounding, floor by arithmetic shift
    always_comb begin
        w_blend = (r8_prod + PROD_W'(HALF)) >>> FRAC_W;
        w_sum = PROD_W'(r8_t0) + w_blend;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
            r8_valid <= 1'b0;
        end else begin
            r7_valid <= i_idx.valid;
            r8_valid <= r7_valid;
        end
    end

    // table read and product registers
    always_ff @(posedge i_clk) begin
        if (i_idx.kind == KIND_EXP) begin
            r7_t0 <= w_exp_rom[i_idx.i0];
            r7_t1 <= w_exp_rom[i_idx.i1];
        end else begin
            r7_t0 <= w_log_rom[i_idx.i0];
            r7_t1 <= w_log_rom[i_idx.i1];
        end
        r7_f <= i_idx.f;
        r8_t0 <= r7_t0;
        r8_prod <= w_prod;
    end

    assign o_res.valid = r8_valid;
    assign o_res.value = w_sum[RES_W-1:0];

endmodule

### design/lei_out_fifo.sv
// output buffer and credit count: holds finished results while the receiver
// stalls and only admits an item when a slot is guaranteed for it
// depends on lei_pkg
module lei_out_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_take,
    input  lei_pkg::t_res                    i_res,
    input  logic                             i_ready,
    output logic                             o_room,
    output logic                             o_valid,
    output logic signed [lei_pkg::RES_W-1:0] o_result_value
);
    import lei_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic signed [RES_W-1:0] r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]        r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]        r_fill, r_owed;
    logic [CNT_W-1:0]        n_fill, n_owed;
    logic                    w_pop;

    assign w_pop = (r_fill != '0) && i_ready;

    // occupancy and items owed a slot (in the pipe or buffered)
    always_comb begin
        n_fill = r_fill;
        if (i_res.valid) begin
            n_fill = n_fill + CNT_W'(1);
        end
        if (w_pop) begin
            n_fill = n_fill - CNT_W'(1);
        end
        n_owed = r_owed;
        if (i_take) begin
            n_owed = n_owed + CNT_W'(1);
        end
        if (w_pop) begin
            n_owed = n_owed - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill <= '0;
            r_owed <= '0;
        end else begin
            r_fill <= n_fill;
            r_owed <= n_owed;
            if (i_res.valid) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_mem[r_wr_ptr] <= i_res.value;
        end
    end

    assign o_room = r_owed < CNT_W'(FIFO_DEPTH);
    assign o_valid = r_fill != '0;
    assign o_result_value = r_mem[r_rd_ptr];

endmodule

### design/log_exp_table_interpolator_top.sv
// Table interpolator for natural log and exp; arguments in signed q16.16, results in signed q4.16.
// Input channel: i_valid / o_ready with i_kind (0 log, 1 exp) and
// i_arg_value. Output channel: o_valid / i_ready with o_result_value.
// Log arguments are clamped to 0.1..10, exp arguments to -2..2, then the
// position over the sample table is split into an entry index and a 16-bit
// fraction that blends two neighboring entries.
// Throughput: one item per cycle, sustained while i_ready stays high.
// Path from input accept to output: the eight-stage pipe (clamp, scale,
// two reciprocal divides by 99 with correction, table read, multiply),
// then the result buffer.
// Results wait in a 16-entry buffer while the receiver stalls; o_ready
// drops only when every buffer slot is claimed by an item in flight or
// buffered, so the pipe itself never stops and nothing is dropped.
// Reset (synchronous, active low) empties the pipe and the buffer; the
// tables are constants and need no fill time.
// depends on lei_pkg, lei_index, lei_interp, lei_out_fifo
module log_exp_table_interpolator_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_kind,
    input  logic signed [lei_pkg::ARG_W-1:0] i_arg_value,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [lei_pkg::RES_W-1:0] o_result_value
);
    import lei_pkg::*;

    logic w_take;
    logic w_room;
    t_idx w_idx;
    t_res w_res;

    assign w_take = i_valid && w_room;
    assign o_ready = w_room;

    // argument to table position
    lei_index u_index (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_take),
        .i_kind      (i_kind),
        .i_arg_value (i_arg_value),
        .o_idx       (w_idx)
    );

    // table lookup and blend
    lei_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (w_idx),
        .o_res   (w_res)
    );

    // result buffer and admission credit
    lei_out_fifo u_out_fifo (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (w_take),
        .i_res          (w_res),
        .i_ready        (i_ready),
        .o_room         (w_room),
        .o_valid        (o_valid),
        .o_result_value (o_result_value)
    );

    // every accepted item reaches the buffer once it has passed all pipe stages
    a_fixed_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> ##PIPE_STAGES w_res.valid)
        else $error("accepted item did not reach the result buffer on time");

    // upper neighbor is the next entry, or the last entry held
    a_neighbor : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_idx.valid |-> (w_idx.i1 == w_idx.i0 + IDX_W'(1)) ||
                        (w_idx.i0 == IDX_LAST && w_idx.i1 == IDX_LAST))
        else $error("upper table index is not the neighbor of the lower one");

    // at the last entry there is nothing left to blend
    a_last_frac : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_idx.valid && w_idx.i0 == IDX_LAST) |-> (w_idx.f == '0))
        else $error("nonzero fraction at the last table entry");

    // reset empties the index pipe
    a_reset_flush : assert property (@(posedge i_clk)
        !i_rst_n |=> !w_idx.valid)
        else $error("index pipe holds an item right after reset");

endmodule

### sim/tb_top.sv
// testbench for log_exp_table_interpolator_top: log/exp lookups checked against an in-bench
// table interpolation predictor, with directed edges, random streams and backpressure
// depends on lei_pkg and log_exp_table_interpolator_top
module tb_top;
    import lei_pkg::*;

    // run limits and predictor constants
    localparam int CYCLE_LIMIT = 400000;
    localparam int END_SETTLE = 20;
    localparam longint unsigned ONE_FIX30 = 64'd1 << 30;
    localparam longint LN2_FIX30 = 744261118;
    localparam longint LOG_SPAN = 6488064;
    localparam longint EXP_SPAN = 262144;
    localparam int LOG_ARG_LO = 6554;
    localparam int LOG_ARG_HI = 655360;
    localparam int EXP_ARG_LO = -131072;
    localparam int EXP_ARG_HI = 131072;

    typedef struct {
        logic                    kind;
        logic signed [ARG_W-1:0] arg;
        logic signed [RES_W-1:0] value;
    } lookup_result_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic                    i_kind;
    logic signed [ARG_W-1:0] i_arg_value;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [RES_W-1:0] o_result_value;

    longint log_samples[TABLE_ENTRIES];
    longint exp_samples[TABLE_ENTRIES];
    lookup_result_t pending_results[$];

    int  mismatch_count;
    int  cycle_count;
    bit  tx_idle_en;
    bit  rx_idle_en;
    int  rx_wait;
    int  rx_hold_len;
    bit  rx_hold_go;
    bit  rx_hold_seen;
    int  rx_hold_left;

    log_exp_table_interpolator_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_arg_value   (i_arg_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_value(o_result_value)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ln(num/den) in q2.30, atanh series after normalizing into [1, 2)
    function automatic longint ln_fix30(input longint unsigned num,
                                        input longint unsigned den);
        longint unsigned x;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned p;
        longint unsigned acc;
        longint          k;
        x = (num << 30) / den;
        k = 0;
        acc = 0;
        if (x == 0) begin
            x = 1;
        end
        while (x >= (ONE_FIX30 << 1)) begin
            x = x >> 1;
            k++;
        end
        while (x < ONE_FIX30) begin
            x = x << 1;
            k--;
        end
        z = ((x - ONE_FIX30) << 30) / (x + ONE_FIX30);
        z2 = (z * z) >> 30;
        p = z;
        for (int j = 0; j < 40 && p != 0; j++) begin
            acc = acc + p / longint'(2 * j + 1);
            p = (p * z2) >> 30;
        end
        return k * LN2_FIX30 + signed'(acc << 1);
    endfunction

    // exp(+/- mag/den) in q2.30, taylor series, reciprocal for negative side
    function automatic longint exp_fix30(input longint unsigned mag,
                                         input longint unsigned den,
                                         input bit neg);
        longint unsigned x;
        longint unsigned acc;
        longint unsigned term;
        x = (mag << 30) / den;
        acc = ONE_FIX30;
        term = ONE_FIX30;
        for (int n = 1; n <= 40 && term != 0; n++) begin
            term = ((term * x) >> 30) / longint'(n);
            acc = acc + term;
        end
        if (neg) begin
            return signed'((64'd1 << 60) / acc);
        end
        return signed'(acc);
    endfunction

    // q2.30 down to q16.16, halves away from zero
    function automatic longint round_to_q16(input longint v);
        if (v >= 0) begin
            return (v + 8192) / 16384;
        end
        return -((-v + 8192) / 16384);
    endfunction

    // evenly spaced samples of ln over 0.1..10 and exp over -2..2
    function automatic void build_sample_tables();
        longint          e;
        longint unsigned m;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            m = TABLE_ENTRIES - 1;
            e = 4 * longint'(i) - 2 * longint'(m);
            log_samples[i] = round_to_q16(ln_fix30(m + 99 * i, 10 * m));
            exp_samples[i] = round_to_q16(exp_fix30((e < 0) ? -e : e, m, e < 0));
        end
    endfunction

    // clamp, split the table position, blend the two neighbors
    function automatic logic signed [RES_W-1:0] interp_lookup(
            input logic kind, input logic signed [ARG_W-1:0] arg);
        longint a;
        longint d;
        longint span;
        longint p;
        longint frac;
        longint i0;
        longint i1;
        longint lo;
        longint hi;
        longint v;
        a = arg;
        if (kind == KIND_LOG) begin
            d = 10 * a - 65536;
            span = LOG_SPAN;
        end else begin
            d = a + 131072;
            span = EXP_SPAN;
        end
        if (d < 0) d = 0;
        if (d > span) d = span;
        p = d * (TABLE_ENTRIES - 1);
        i0 = p / span;
        frac = ((p % span) * 65536) / span;
        if (i0 > TABLE_ENTRIES - 1) i0 = TABLE_ENTRIES - 1;
        i1 = (i0 + 1 > TABLE_ENTRIES - 1) ? TABLE_ENTRIES - 1 : i0 + 1;
        lo = (kind == KIND_LOG) ? log_samples[i0] : exp_samples[i0];
        hi = (kind == KIND_LOG) ? log_samples[i1] : exp_samples[i1];
        v = lo * (65536 - frac) + hi * frac + 32768;
        v = v >>> 16;
        return v[RES_W-1:0];
    endfunction

    // argument mix: mostly in range, some near the clamp points, some anywhere
    function automatic logic signed [ARG_W-1:0] random_arg(input logic kind);
        int sel;
        int edge_pt;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            if (kind == KIND_LOG) begin
                return $urandom_range(LOG_ARG_LO, LOG_ARG_HI);
            end
            return int'($urandom_range(0, EXP_ARG_HI - EXP_ARG_LO)) + EXP_ARG_LO;
        end else if (sel < 8) begin
            if (kind == KIND_LOG) begin
                edge_pt = $urandom_range(0, 1) ? LOG_ARG_HI : LOG_ARG_LO;
            end else begin
                edge_pt = $urandom_range(0, 1) ? EXP_ARG_HI : EXP_ARG_LO;
            end
            return edge_pt + int'($urandom_range(0, 128)) - 64;
        end
        return $urandom;
    endfunction

    // offer one item, after a random gap when tx_idle_en is set, and hold it until accepted
    task automatic send_item(input logic kind, input logic signed [ARG_W-1:0] arg);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_arg_value <= arg;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back('{kind, arg, interp_lookup(kind, arg)});
    endtask

    // sender stops until every outstanding result is back
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        logic kind;
        repeat (count) begin
            kind = $urandom_range(0, 1);
            send_item(kind, random_arg(kind));
        end
    endtask

    // clamp points, sign extremes and in-range values of both functions
    task automatic test_directed_edges();
        send_item(KIND_LOG, 32'sh8000_0000);
        send_item(KIND_LOG, 32'sh7fff_ffff);
        send_item(KIND_LOG, 0);
        send_item(KIND_LOG, 6553);
        send_item(KIND_LOG, LOG_ARG_LO);
        send_item(KIND_LOG, 65536);
        send_item(KIND_LOG, 300000);
        send_item(KIND_LOG, LOG_ARG_HI - 1);
        send_item(KIND_LOG, LOG_ARG_HI);
        send_item(KIND_LOG, LOG_ARG_HI + 1);
        send_item(KIND_LOG, -1);
        send_item(KIND_EXP, 32'sh8000_0000);
        send_item(KIND_EXP, 32'sh7fff_ffff);
        send_item(KIND_EXP, EXP_ARG_LO - 1);
        send_item(KIND_EXP, EXP_ARG_LO);
        send_item(KIND_EXP, -65536);
        send_item(KIND_EXP, -1);
        send_item(KIND_EXP, 0);
        send_item(KIND_EXP, 65536);
        send_item(KIND_EXP, EXP_ARG_HI);
        send_item(KIND_EXP, EXP_ARG_HI + 1);
        wait_drained();
    endtask

    // random stream with gaps on both sides
    task automatic test_random_stream();
        tx_idle_en = 1'b1;
        rx_idle_en <= 1'b1;
        send_random(500);
        wait_drained();
    endtask

    // back to back at full rate
    task automatic test_full_rate();
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
        send_random(200);
        wait_drained();
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_output_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
        rx_hold_len <= 400;
        rx_hold_go <= ~rx_hold_go;
        send_random(80);
        wait_drained();
    endtask

    // bursts separated by full drains
    task automatic test_drain_pauses();
        tx_idle_en = 1'b1;
        rx_idle_en <= 1'b1;
        repeat (4) begin
            send_random(50);
            wait_drained();
        end
    endtask

    // only one side idles at a time
    task automatic test_one_sided_idle();
        tx_idle_en = 1'b1;
        rx_idle_en <= 1'b0;
        send_random(75);
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b1;
        send_random(75);
        wait_drained();
    endtask

    // main sequence
    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_kind <= KIND_LOG;
        i_arg_value <= '0;
        i_ready <= 1'b0;
        rx_idle_en <= 1'b1;
        rx_hold_len <= 0;
        rx_hold_go <= 1'b0;
        tx_idle_en = 1'b1;
        mismatch_count = 0;
        build_sample_tables();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_random_stream();
        test_full_rate();
        test_output_backpressure();
        test_drain_pauses();
        test_one_sided_idle();

        repeat (END_SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // receiver: random ready gaps, long hold on request, result check
    always @(posedge i_clk) begin : result_check
        lookup_result_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_wait = 0;
            rx_hold_left = 0;
            rx_hold_seen = rx_hold_go;
        end else begin
            if (rx_hold_go != rx_hold_seen) begin
                rx_hold_seen = rx_hold_go;
                rx_hold_left = rx_hold_len;
            end
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %0d with nothing pending",
                                 o_result_value);
                end else begin
                    want = pending_results.pop_front();
                    if (o_result_value !== want.value) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch kind %0d arg %0d: expected %0d, got %0d",
                                     want.kind, want.arg, want.value, o_result_value);
                    end
                end
                rx_wait = rx_idle_en ? $urandom_range(0, 11) : 0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial cycle_count = 0;

endmodule

### filelist.f
design/lei_pkg.sv
design/lei_index.sv
design/lei_interp.sv
design/lei_out_fifo.sv
design/log_exp_table_interpolator_top.sv
sim/tb_top.sv
